FILE: hw/rtl/drl_pkg.sv
// Shared types, constants and helper functions of the data run list decoder.
package drl_pkg;

  localparam int unsigned MaxFieldBytes = 8;
  localparam logic [63:0] AllOnes       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    StRun    = 2'd0,
    StSparse = 2'd1,
    StEnd    = 2'd2,
    StBad    = 2'd3
  } status_e;

  // One command from the byte parser to the run executor.
  typedef struct packed {
    status_e     kind;
    logic        restart;
    logic [63:0] start_vcn;
    logic [63:0] run_length;
    logic [63:0] offset;
  } cmd_t;

  // Sign-extends a little-endian field of nbytes bytes to 64 bits.
  function automatic logic [63:0] sign_extend(input logic [63:0] v, input logic [3:0] nbytes);
    logic [63:0] r;
    r = v;
    for (int k = 1; k < 8; k++) begin
      if (nbytes == 4'(k) && v[8*k-1]) begin
        r = v | (AllOnes << (8 * k));
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/data_run_list_decoder.sv
// Top level of the data run list decoder: parser, command queue and run executor.
//
// Usage: the mapping-pairs list of a nonresident attribute enters one byte per
// transaction on the slave stream. tuser marks the first header byte of a new
// list; that transaction also carries the attribute's lowest virtual cluster,
// which restarts the virtual cluster count and clears the logical cluster sum.
// Header, length and offset bytes are taken one per cycle, back to back, while the queue has room.
// Each completed run, each end-of-list header and each bad header gives one
// transaction on the master stream; tuser carries its status (run, sparse run,
// end of list, bad header) and tdata the start cluster, length and cluster.
// The command for a result is written into the queue when the byte that
// completes it is accepted, and moves into the output register, which drives
// tvalid on the master side, as soon as that register is free or being read.
// While the receiver does not stall, throughput is one byte per cycle, set
// by the byte parser loop and the two 64-bit adders of the run executor, each
// working once per cycle. When the receiver stalls, results wait in the output
// register and up to two commands fill the queue; tready on the slave side then
// drops until room is freed. Reset puts the parser in its idle state, in which
// bytes without the first-byte mark are dropped, and clears both cluster counts.
module data_run_list_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: in_byte [7:0], start_vcn [71:8].
  input  logic [71:0]   s_axis_tdata,
  // tuser: begin_list [0].
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: run_start_vcn [63:0], run_length [127:64], run_lcn [191:128].
  output logic [191:0]  m_axis_tdata,
  // tuser: status [1:0].
  output logic [1:0]    m_axis_tuser
);
  import drl_pkg::*;

  logic push, q_full, q_valid, pop;
  cmd_t cmd_in, cmd_out;

  // The parser turns the byte stream into one command per result.
  drl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata[7:0]),
    .begin_list_i (s_axis_tuser),
    .start_vcn_i  (s_axis_tdata[71:8]),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  // The queue lets the parser run on while the receiver stalls.
  drl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (cmd_out)
  );

  // The executor applies the cluster sums in command order.
  drl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .cmd_i           (cmd_out),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .status_o        (m_axis_tuser),
    .run_start_vcn_o (m_axis_tdata[63:0]),
    .run_length_o    (m_axis_tdata[127:64]),
    .run_lcn_o       (m_axis_tdata[191:128])
  );

endmodule

FILE: hw/rtl/drl_front.sv
// Byte parser: tracks header, length and offset fields and issues run, end-of-list and bad-header commands.
module drl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                begin_list_i,
  input  logic [63:0]         start_vcn_i,
  input  logic                q_full_i,
  output logic                push_o,
  output drl_pkg::cmd_t       cmd_o
);
  import drl_pkg::*;

  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhLength = 4'b0010,
    PhOffset = 4'b0100,
    PhIdle   = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d, phase_eff;
  logic [3:0]  len_size_q, len_size_d;
  logic [3:0]  off_size_q, off_size_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] len_q, len_d;
  logic        pend_q, pend_d;
  logic [63:0] pend_vcn_q, pend_vcn_d;

  logic        accept;
  logic [3:0]  hdr_ls, hdr_os;
  logic [63:0] acc_new;
  logic [3:0]  cnt_next;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign phase_eff  = begin_list_i ? PhHeader : phase_q;
  assign hdr_ls     = in_byte_i[3:0];
  assign hdr_os     = in_byte_i[7:4];
  assign acc_new    = acc_q | ({56'd0, in_byte_i} << {idx_q, 3'b000});
  assign cnt_next   = {1'b0, idx_q} + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    len_size_d = len_size_q;
    off_size_d = off_size_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    len_d      = len_q;
    pend_d     = pend_q;
    pend_vcn_d = pend_vcn_q;
    push_o     = 1'b0;
    cmd_o.kind       = StRun;
    cmd_o.restart    = begin_list_i || pend_q;
    cmd_o.start_vcn  = begin_list_i ? start_vcn_i : pend_vcn_q;
    cmd_o.run_length = len_q;
    cmd_o.offset     = 64'd0;

    if (accept) begin
      if (begin_list_i) begin
        pend_d     = 1'b1;
        pend_vcn_d = start_vcn_i;
      end
      unique case (phase_eff)
        PhHeader: begin
          if (in_byte_i == 8'd0) begin
            push_o     = 1'b1;
            cmd_o.kind = StEnd;
            phase_d    = PhIdle;
          end else if (32'(hdr_ls) > MaxFieldBytes || 32'(hdr_os) > MaxFieldBytes) begin
            push_o     = 1'b1;
            cmd_o.kind = StBad;
            phase_d    = PhIdle;
          end else begin
            len_size_d = hdr_ls;
            off_size_d = hdr_os;
            idx_d      = 3'd0;
            acc_d      = 64'd0;
            len_d      = 64'd0;
            phase_d    = (hdr_ls != 4'd0) ? PhLength : PhOffset;
          end
        end
        PhLength: begin
          acc_d = acc_new;
          idx_d = idx_q + 3'd1;
          if (cnt_next >= len_size_q) begin
            idx_d = 3'd0;
            acc_d = 64'd0;
            if (off_size_q == 4'd0) begin
              push_o           = 1'b1;
              cmd_o.kind       = StSparse;
              cmd_o.run_length = sign_extend(acc_new, len_size_q);
              phase_d          = PhHeader;
            end else begin
              len_d   = sign_extend(acc_new, len_size_q);
              phase_d = PhOffset;
            end
          end
        end
        PhOffset: begin
          acc_d = acc_new;
          idx_d = idx_q + 3'd1;
          if (cnt_next >= off_size_q) begin
            push_o       = 1'b1;
            cmd_o.kind   = StRun;
            cmd_o.offset = sign_extend(acc_new, off_size_q);
            idx_d        = 3'd0;
            phase_d      = PhHeader;
          end
        end
        PhIdle: begin
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
      if (push_o) begin
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      len_size_q <= 4'd0;
      off_size_q <= 4'd0;
      idx_q      <= 3'd0;
      acc_q      <= 64'd0;
      len_q      <= 64'd0;
      pend_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      len_size_q <= len_size_d;
      off_size_q <= off_size_d;
      idx_q      <= idx_d;
      acc_q      <= acc_d;
      len_q      <= len_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vcn_q <= pend_vcn_d;
  end

endmodule

FILE: hw/rtl/drl_queue.sv
// Two-entry command queue between the byte parser and the run executor.
module drl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  drl_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output drl_pkg::cmd_t cmd_o
);
  import drl_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/drl_back.sv
// Run executor: keeps the running cluster numbers and holds the output register.
module drl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  drl_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [63:0]   run_start_vcn_o,
  output logic [63:0]   run_length_o,
  output logic [63:0]   run_lcn_o
);
  import drl_pkg::*;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [63:0] vcn_out_q, len_out_q, lcn_out_q;
  logic [63:0] lcn_q, lcn_d, vcn_q, vcn_d;
  logic [63:0] lcn_base, vcn_base, lcn_sum;
  status_e     st_d;
  logic [63:0] vcn_out_d, len_out_d, lcn_out_d;

  assign pop_o    = q_valid_i && (!out_valid_q || out_ready_i);
  assign lcn_base = cmd_i.restart ? 64'd0 : lcn_q;
  assign vcn_base = cmd_i.restart ? cmd_i.start_vcn : vcn_q;
  assign lcn_sum  = lcn_base + cmd_i.offset;

  always_comb begin
    st_d      = cmd_i.kind;
    lcn_d     = lcn_base;
    vcn_d     = vcn_base;
    vcn_out_d = 64'd0;
    len_out_d = 64'd0;
    lcn_out_d = 64'd0;
    case (cmd_i.kind)
      StRun: begin
        lcn_d     = lcn_sum;
        vcn_d     = vcn_base + cmd_i.run_length;
        vcn_out_d = vcn_base;
        len_out_d = cmd_i.run_length;
        lcn_out_d = lcn_sum;
      end
      StSparse: begin
        vcn_d     = vcn_base + cmd_i.run_length;
        vcn_out_d = vcn_base;
        len_out_d = cmd_i.run_length;
      end
      StEnd: begin
        vcn_out_d = vcn_base;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lcn_q       <= 64'd0;
      vcn_q       <= 64'd0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        lcn_q       <= lcn_d;
        vcn_q       <= vcn_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= st_d;
      vcn_out_q <= vcn_out_d;
      len_out_q <= len_out_d;
      lcn_out_q <= lcn_out_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign run_start_vcn_o = vcn_out_q;
  assign run_length_o    = len_out_q;
  assign run_lcn_o       = lcn_out_q;

endmodule

FILE: dv/data_run_list_decoder_tb.sv
// Self-checking testbench of the data run list decoder, with a mapping-pairs predictor.
`timescale 1ns / 100ps

module data_run_list_decoder_tb;
  import drl_pkg::*;

  // The watchdog ends the run after this many cycles without any transaction.
  localparam int unsigned StallLimit = 1000;
  // Number of counted input bytes at which the random part stops.
  localparam int unsigned ByteTarget = 800;
  // Cycles left for stray results after the last expected one has arrived.
  localparam int unsigned TailCycles = 8;

  // Decoding phase of the predictor; it mirrors the parser of the block.
  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhLength = 2'd1,
    PhOffset = 2'd2,
    PhIdle   = 2'd3
  } phase_e;

  // One decoded run as it should leave the block.
  typedef struct {
    status_e     status;
    logic [63:0] start_vcn;
    logic [63:0] length;
    logic [63:0] lcn;
  } run_t;

  // Predicts the runs of a mapping-pairs list from its bytes and checks the
  // block's results against them in order.
  class run_list_model;
    phase_e      phase;
    logic [3:0]  len_size;
    logic [3:0]  off_size;
    logic [3:0]  idx;
    logic [63:0] len_acc;
    logic [63:0] off_acc;
    logic [63:0] lcn;
    logic [63:0] vcn;
    run_t        expected_runs[$];
    int unsigned errors;

    function new();
      phase    = PhIdle;
      len_size = '0;
      off_size = '0;
      idx      = '0;
      len_acc  = '0;
      off_acc  = '0;
      lcn      = '0;
      vcn      = '0;
      errors   = 0;
    endfunction

    // Appends one predicted run behind the older ones.
    function void note_run(run_t r);
      expected_runs.insert(expected_runs.size(), r);
    endfunction

    // Fields of one to seven bytes take the sign of their top byte.
    function logic [63:0] extend(logic [63:0] v, logic [3:0] n);
      if (n == 0 || n >= 8) begin
        return v;
      end
      if (v[8*n-1]) begin
        v = v | ({64{1'b1}} << (8 * n));
      end
      return v;
    endfunction

    function void close_run(bit sparse);
      logic [63:0] len;
      run_t        r;
      len         = extend(len_acc, len_size);
      r.start_vcn = vcn;
      r.length    = len;
      vcn         = vcn + len;
      phase       = PhHeader;
      idx         = '0;
      if (sparse) begin
        r.status = StSparse;
        r.lcn    = '0;
      end else begin
        lcn      = lcn + extend(off_acc, off_size);
        r.status = StRun;
        r.lcn    = lcn;
      end
      note_run(r);
    endfunction

    // Returns 0 when the byte is dropped by an idle parser.
    function bit take_byte(logic [7:0] b, logic first, logic [63:0] start);
      run_t r;
      if (first) begin
        phase    = PhHeader;
        len_size = '0;
        off_size = '0;
        idx      = '0;
        len_acc  = '0;
        off_acc  = '0;
        lcn      = '0;
        vcn      = start;
      end
      case (phase)
        PhHeader: begin
          if (b == 8'h00) begin
            phase       = PhIdle;
            r.status    = StEnd;
            r.start_vcn = vcn;
            r.length    = '0;
            r.lcn       = '0;
            note_run(r);
          end else if (b[3:0] > MaxFieldBytes || b[7:4] > MaxFieldBytes) begin
            phase       = PhIdle;
            r.status    = StBad;
            r.start_vcn = '0;
            r.length    = '0;
            r.lcn       = '0;
            note_run(r);
          end else begin
            len_size = b[3:0];
            off_size = b[7:4];
            idx      = '0;
            len_acc  = '0;
            off_acc  = '0;
            phase    = (b[3:0] != 0) ? PhLength : PhOffset;
          end
        end
        PhLength: begin
          len_acc = len_acc | (64'(b) << (8 * idx[2:0]));
          idx     = idx + 4'd1;
          if (idx >= len_size) begin
            if (off_size == 0) begin
              close_run(1'b1);
            end else begin
              idx   = '0;
              phase = PhOffset;
            end
          end
        end
        PhOffset: begin
          off_acc = off_acc | (64'(b) << (8 * idx[2:0]));
          idx     = idx + 4'd1;
          if (idx >= off_size) begin
            close_run(1'b0);
          end
        end
        default: begin
          return 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_run(status_e st, logic [63:0] v, logic [63:0] l, logic [63:0] c);
      run_t e;
      if (expected_runs.size() == 0) begin
        $error("result with status %0d arrived while none was expected", st);
        errors++;
        return;
      end
      e = expected_runs.pop_front();
      compare_field("status", 64'(e.status), 64'(st));
      compare_field("run_start_vcn", e.start_vcn, v);
      compare_field("run_length", e.length, l);
      compare_field("run_lcn", e.lcn, c);
    endfunction
  endclass

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [71:0]   s_axis_tdata  = '0;
  logic          s_axis_tuser  = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [191:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;

  run_list_model decoder_model = new();
  // Counts the bytes that the parser actually works on; dropped bytes are not counted.
  int unsigned   bytes_taken   = 0;
  // While set, neither side inserts idle cycles.
  bit            calm          = 1'b0;

  data_run_list_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Idle stretch between transactions: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // Drives one byte, waits for its transaction and hands it to the predictor.
  // tvalid stays high into the next byte unless a gap is drawn.
  task automatic send_byte(logic [7:0] b, logic first, logic [63:0] start);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {start, b};
    s_axis_tuser  <= first;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    if (decoder_model.take_byte(b, first, start)) begin
      bytes_taken++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends a header and its little-endian length and offset bytes. Only the
  // header may carry the list start flag; later bytes carry junk cluster values.
  task automatic send_run(logic first, logic [63:0] start, logic [3:0] ls, logic [3:0] os,
                          logic [63:0] len, logic [63:0] off);
    int k;
    send_byte({os, ls}, first, start);
    for (k = 0; k < ls; k++) begin
      send_byte(len[8*k +: 8], 1'b0, rand64());
    end
    for (k = 0; k < os; k++) begin
      send_byte(off[8*k +: 8], 1'b0, rand64());
    end
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (decoder_model.expected_runs.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // The receiver alternates ready stretches with random stalls.
  initial begin : receiver
    int gap;
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      decoder_model.check_run(status_e'(m_axis_tuser), m_axis_tdata[63:0],
                              m_axis_tdata[127:64], m_axis_tdata[191:128]);
    end
  end

  // A run that stops moving in both directions for too long is a failure.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int          pick;
    int          nruns;
    int          term;
    int          ls;
    int          os;
    int          cut;
    int          r;
    int unsigned list_no;
    logic        lead;
    logic [63:0] start;
    logic [7:0]  hdr;

    list_no = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The parser is idle after reset, so a byte without the
    // list start flag must be dropped without a result.
    send_byte(8'h11, 1'b0, 64'h0);
    // Small run with a negative one-byte offset, so that the logical cluster wraps
    // below zero, starting near the top of the virtual cluster range.
    send_run(1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 4'd1, 4'd1, 64'h05, 64'hFF);
    // Both fields at their largest size, with extreme values.
    send_run(1'b0, rand64(), 4'd8, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    // Sparse run: no offset bytes, and its length byte has the sign bit set.
    send_run(1'b0, rand64(), 4'd1, 4'd0, 64'h80, 64'h0);
    // No length bytes: the run length is zero and the offset follows at once.
    send_run(1'b0, rand64(), 4'd0, 4'd1, 64'h0, 64'h7F);
    // Offset size above the limit ends the list with a bad header.
    send_byte(8'hF1, 1'b0, rand64());
    // Idle again: both bytes are dropped, a zero byte included.
    send_byte(8'h00, 1'b0, rand64());
    send_byte(8'hFF, 1'b0, rand64());
    // New list whose first header has a length size above the limit.
    send_byte(8'h19, 1'b1, rand64());
    // A list cut off in the middle of a run and restarted by an empty list.
    send_byte(8'h21, 1'b1, rand64());
    send_byte(8'hAA, 1'b0, rand64());
    send_byte(8'h00, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    drain_results();

    // Random part: mostly complete lists with random content, the rest broken
    // lists and noise.
    while (bytes_taken < ByteTarget) begin
      list_no++;
      calm  = ($urandom_range(0, 4) == 0);
      start = rand64();
      if (list_no % 40 == 0) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        lead  = 1'b1;
        nruns = $urandom_range(0, 6);
        for (r = 0; r < nruns; r++) begin
          ls = $urandom_range(0, 8);
          os = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
          if (ls == 0 && os == 0) begin
            ls = 1;
          end
          send_run(lead, start, 4'(ls), 4'(os), rand64(), rand64());
          lead = 1'b0;
        end
        term = $urandom_range(0, 19);
        if (term < 17) begin
          send_byte(8'h00, lead, start);
        end else if (term < 19) begin
          if ($urandom_range(0, 1) == 1) begin
            hdr = {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))};
          end else begin
            hdr = {4'($urandom_range(9, 15)), 4'($urandom_range(0, 15))};
          end
          send_byte(hdr, lead, start);
        end
      end else if (pick < 90) begin
        // Header followed by fewer bytes than it announces; the next list
        // start flag abandons the run.
        ls = $urandom_range(1, 8);
        os = $urandom_range(0, 8);
        send_byte({4'(os), 4'(ls)}, 1'b1, start);
        cut = $urandom_range(0, ls + os - 1);
        repeat (cut) send_byte(8'($urandom), 1'b0, rand64());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom), $urandom_range(0, 9) == 0, rand64());
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (decoder_model.expected_runs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (decoder_model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/drl_pkg.sv
hw/rtl/drl_front.sv
hw/rtl/drl_queue.sv
hw/rtl/drl_back.sv
hw/rtl/data_run_list_decoder.sv
dv/data_run_list_decoder_tb.sv
